// ===== design/tdp_pkg.sv =====
`default_nettype none

package tdp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RESULT
  } tdp_state_t;

  // Status of the shared remainder unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } tdp_div_status_t;

  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SQUARE  = 4;
  localparam int unsigned SMALLEST_PRIME = 2;

endpackage

`default_nettype wire

// ===== design/tdp_divider.sv =====
`default_nettype none

module tdp_divider #(
  parameter int VALUE_WIDTH = 16,
  parameter int DIV_WIDTH   = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0]   divisor,
  output tdp_pkg::tdp_div_status_t    status,
  output logic [DIV_WIDTH-1:0]        remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  logic [DIV_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_WIDTH:0]     trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  // Restoring remainder: one dividend bit enters the partial remainder per cycle.
  always_comb begin
    trial     = {rem_r, shift_r[VALUE_WIDTH-1]};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (start) begin
      busy_nxt  = 1'b1;
      count_nxt = CW'(VALUE_WIDTH);
      shift_nxt = dividend;
      rem_nxt   = '0;
    end else if (busy_r) begin
      shift_nxt = shift_r << 1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DIV_WIDTH'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DIV_WIDTH-1:0];
      end
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign remainder   = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("remainder unit did not start");

  a_done_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < divisor))
    else $error("remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done while still busy");

endmodule

`default_nettype wire

// ===== design/trial_division_prime_test.sv =====
// Trial-division primality test. Each input word carries one candidate; its low
// VALUE_WIDTH bits are tested and one output word returns is_prime (0 and 1 are
// not prime). Divisors d = 2, 3, ... are tried while d*d <= candidate; the square
// is kept incrementally, so no multiplier is used. Each divisor is checked by the
// shared bit-serial remainder unit; at most 254 divisors are tried for 16-bit
// candidates. One item is in work at a time; the result sits in an output
// register, so the next word is taken while an earlier result still waits
// downstream.
`default_nettype none

module trial_division_prime_test #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_candidate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_prime
);

  localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SW = VALUE_WIDTH + 2;

  tdp_pkg::tdp_state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [SW-1:0]          sq_r, sq_nxt;
  logic                   result_r, result_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic                   div_start;
  logic [DW-1:0]          div_rem;
  tdp_pkg::tdp_div_status_t div_st;
  logic [VALUE_WIDTH-1:0] cand;
  logic                   in_accept;
  logic                   out_free;

  tdp_divider #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (div_st),
    .remainder(div_rem)
  );

  assign cand      = VALUE_WIDTH'(in_candidate);
  assign in_stall  = (state_r != tdp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    result_r    <= result_nxt;
    out_prime_r <= out_prime_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    result_nxt    = result_r;
    div_start     = 1'b0;
    out_prime_nxt = out_prime_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      tdp_pkg::ST_IDLE: begin
        if (in_accept) begin
          n_nxt  = cand;
          d_nxt  = DW'(tdp_pkg::FIRST_DIVISOR);
          sq_nxt = SW'(tdp_pkg::FIRST_SQUARE);
          if (cand < VALUE_WIDTH'(tdp_pkg::SMALLEST_PRIME)) begin
            result_nxt = 1'b0;
            state_nxt  = tdp_pkg::ST_RESULT;
          end else begin
            state_nxt = tdp_pkg::ST_CHECK;
          end
        end
      end
      tdp_pkg::ST_CHECK: begin
        if (sq_r > SW'(n_r)) begin
          result_nxt = 1'b1;
          state_nxt  = tdp_pkg::ST_RESULT;
        end else begin
          div_start = 1'b1;
          state_nxt = tdp_pkg::ST_DIV;
        end
      end
      tdp_pkg::ST_DIV: begin
        if (div_st.done) begin
          if (div_rem == '0) begin
            result_nxt = 1'b0;
            state_nxt  = tdp_pkg::ST_RESULT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SW'({d_r, 1'b1});
            d_nxt     = d_r + DW'(1);
            state_nxt = tdp_pkg::ST_CHECK;
          end
        end
      end
      tdp_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = result_r;
          state_nxt     = tdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != tdp_pkg::ST_IDLE))
    else $error("accepted word did not start a test");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_DIV) |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle remainder unit");

  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_CHECK || state_r == tdp_pkg::ST_DIV)
      |-> (d_r >= DW'(tdp_pkg::FIRST_DIVISOR)))
    else $error("divisor below two");

  a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_CHECK) |-> (sq_r > SW'(d_r)))
    else $error("square bookkeeping lost");

endmodule

`default_nettype wire

// ===== sim/tb_trial_division_prime_test.sv =====
`timescale 1ns / 100ps

module tb_trial_division_prime_test;

  localparam int VALUE_WIDTH = 16;
  localparam int RANDOM_WORDS = 120;
  localparam int PROBE_COUNT = 20;

  typedef struct {
    logic [15:0] cand;
    bit          typed;
    logic        verdict;
  } probe_t;

  typedef struct {
    logic [15:0] cand;
    logic        is_prime;
  } verdict_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_candidate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_prime;

  // While calm is set, neither side inserts gaps or stalls.
  logic        calm = 1'b0;
  int          mismatch_cnt = 0;
  verdict_t    verdict_q[$];

  // Rows with typed set carry a verdict that is obvious; the rest go through the
  // trial-division predictor.
  probe_t probes [0:PROBE_COUNT-1] = '{
    '{16'd0,      1'b1, 1'b0},
    '{16'd1,      1'b1, 1'b0},
    '{16'd2,      1'b1, 1'b1},
    '{16'd3,      1'b1, 1'b1},
    '{16'd4,      1'b1, 1'b0},
    '{16'd65535,  1'b1, 1'b0},
    '{16'd65534,  1'b1, 1'b0},
    '{16'd65521,  1'b1, 1'b1},
    '{16'd32768,  1'b1, 1'b0},
    '{16'd5,      1'b0, 1'b0},
    '{16'd7,      1'b0, 1'b0},
    '{16'd9,      1'b0, 1'b0},
    '{16'd25,     1'b0, 1'b0},
    '{16'd49,     1'b0, 1'b0},
    '{16'd961,    1'b0, 1'b0},
    '{16'd8191,   1'b0, 1'b0},
    '{16'd32767,  1'b0, 1'b0},
    '{16'd65025,  1'b0, 1'b0},
    '{16'h5555,   1'b0, 1'b0},
    '{16'hAAAA,   1'b0, 1'b0}
  };

  trial_division_prime_test #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_candidate (in_candidate),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic trial_divide_verdict(input logic [15:0] raw);
    logic [63:0] n;
    logic [63:0] d;
    n = 64'(raw) & ((64'd1 << VALUE_WIDTH) - 64'd1);
    if (n < 64'd2) begin
      return 1'b0;
    end
    for (d = 64'd2; d * d <= n; d++) begin
      if (n % d == 64'd0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Offers one word and returns once it has been taken; the verdict is queued
  // at the accepting edge.
  task automatic offer_candidate(input logic [15:0] cand, input logic verdict);
    verdict_t entry;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= cand;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    entry.cand     = cand;
    entry.is_prime = verdict;
    verdict_q.push_back(entry);
  endtask

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("is_prime: expected no word, got %0b", out_is_prime);
        mismatch_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (out_is_prime !== want.is_prime) begin
          $error("is_prime: expected %0b, got %0b (candidate %0d)",
                 want.is_prime, out_is_prime, want.cand);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int          pick;
    logic [15:0] cand;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PROBE_COUNT; i++) begin
      offer_candidate(probes[i].cand, probes[i].typed ? probes[i].verdict
                                                      : trial_divide_verdict(probes[i].cand));
    end

    // Most random words are small so the divisor loop stays short; a few span
    // the full 16-bit range to reach the longest searches.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm <= (i >= 50 && i < 90);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        cand = 16'($urandom_range(0, 1023));
      end else if (pick < 92) begin
        cand = 16'($urandom_range(1024, 8191));
      end else begin
        cand = 16'($urandom_range(0, 65535));
      end
      offer_candidate(cand, trial_divide_verdict(cand));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
